// ----- rtl/core/prm_pkg.sv -----
// Package for the priority region map table: sizes, codes and shared types.
// Depends on nothing; every other file of the block uses it.

package prm_pkg;

    // Table depth and derived widths.
    localparam int MAX_MAPS = 16;
    localparam int IDX_W    = $clog2(MAX_MAPS);
    localparam int CNT_W    = $clog2(MAX_MAPS + 1);
    localparam int ID_W     = CNT_W;

    // Command codes.
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_TOP    = 3'd2;
    localparam logic [2:0] CMD_BOTTOM = 3'd3;
    localparam logic [2:0] CMD_VLOOK  = 3'd4;
    localparam logic [2:0] CMD_PLOOK  = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_WRAP = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [4:0]  map_id;
        logic [15:0] fd;
        logic [2:0]  perm;
        logic [63:0] delta;
        logic [63:0] addr;
        logic [63:0] size;
        logic [63:0] phys_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  map_id_res;
        logic [15:0] fd_res;
        logic [2:0]  perm_res;
        logic [63:0] map_base;
        logic [63:0] map_size;
        logic [63:0] delta_res;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [15:0]     fd;
        logic [2:0]      perm;
        logic [63:0]     base;
        logic [63:0]     size;
        logic [63:0]     delta;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap;
        logic eval;
        logic step;
        logic place;
        logic load_out;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic move_hit;
        logic shift_done;
    } ctl_sts_t;

    // Builds a hit result from a table entry.
    function automatic rsp_t report(input entry_t e);
        rsp_t r;
        r.status     = ST_OK;
        r.map_id_res = 5'(e.id);
        r.fd_res     = e.fd;
        r.perm_res   = e.perm;
        r.map_base   = e.base;
        r.map_size   = e.size;
        r.delta_res  = e.delta;
        return r;
    endfunction

endpackage

// ----- rtl/core/prm_if.sv -----
// Handshake interfaces for the request and result channels.
// Depends on prm_pkg for the payload types.

interface prm_req_if;
    logic          valid;
    logic          ready;
    prm_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface prm_rsp_if;
    logic          valid;
    logic          ready;
    prm_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/priority_region_map_table_unit.sv -----
// Top level of the priority region map table.
// Depends on prm_pkg, prm_if, prm_ctrl and prm_dpath.
//
// Usage: requests arrive on req, one command per transfer; each request
// yields exactly one result transfer on rsp, in request order.
// Lookups, adds and moves of an absent id go from capture through evaluation
// straight to the result hand-off. Delete, move-to-top and move-to-bottom shift the
// table one slot per cycle through a single slot read port, moving up to
// MAX_MAPS - 1 slots before the place step.
// One request is in work at a time; req is ready again in the cycle in which
// the result is first presented, so a new request can be taken while the
// previous result still waits on a stalled receiver.
// If the receiver stalls, the finished result holds in the output register
// and the next command waits before its result is loaded.
// Reset empties the table at once; slot contents are not cleared.

module priority_region_map_table_unit
(
    input  logic       clk,
    input  logic       rst_n,
    prm_req_if.sink    req,
    prm_rsp_if.source  rsp
);

    prm_pkg::ctl_cmd_t ctl_cmd;
    prm_pkg::ctl_sts_t ctl_sts;

    prm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (ctl_cmd),
        .sts       (ctl_sts)
    );

    prm_dpath u_dpath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.payload),
        .rsp_data (rsp.payload),
        .cmd      (ctl_cmd),
        .sts      (ctl_sts)
    );

endmodule

// ----- rtl/core/prm_ctrl.sv -----
// Controller state machine of the region table: sequences capture, evaluation,
// slot shifting, placement and result hand-off. Depends on prm_pkg.

module prm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output prm_pkg::ctl_cmd_t cmd,
    input  prm_pkg::ctl_sts_t sts
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_PLACE  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The output register may be loaded when empty or when its transfer completes.
    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.cap    = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.move_hit ? S_SHIFT : S_FINISH;
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // Evaluation lasts exactly one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |=> state_reg != S_EVAL)
        else $error("evaluation held for more than one cycle");

    // A result is never loaded over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp_ready))
        else $error("result register overwritten");

    // A shift step is only issued while slots remain to be moved.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !sts.shift_done)
        else $error("shift step past the end");
`endif

endmodule

// ----- rtl/core/prm_dpath.sv -----
// Datapath of the region table: slot registers, parallel matching, slot
// shifting and the result register. Depends on prm_pkg.

module prm_dpath
(
    input  logic              clk,
    input  logic              rst_n,
    input  prm_pkg::req_t     req_data,
    output prm_pkg::rsp_t     rsp_data,
    input  prm_pkg::ctl_cmd_t cmd,
    output prm_pkg::ctl_sts_t sts
);

    prm_pkg::entry_t                slot_reg [prm_pkg::MAX_MAPS];
    prm_pkg::entry_t                hold_reg;
    prm_pkg::req_t                  item_reg;
    prm_pkg::rsp_t                  res_reg;
    prm_pkg::rsp_t                  out_reg;
    prm_pkg::rsp_t                  res_next;
    logic [prm_pkg::CNT_W-1:0]      cnt_reg;
    logic [prm_pkg::IDX_W-1:0]      ptr_reg;

    logic [prm_pkg::MAX_MAPS-1:0]   live;
    logic [prm_pkg::MAX_MAPS-1:0]   vhit;
    logic [prm_pkg::MAX_MAPS-1:0]   phit;
    logic [prm_pkg::MAX_MAPS-1:0]   idhit;
    logic [prm_pkg::MAX_MAPS:0]     used;
    logic [prm_pkg::IDX_W-1:0]      vidx, pidx, fidx, rd_addr;
    logic [prm_pkg::ID_W-1:0]       free_id;
    logic [63:0]                    pend [prm_pkg::MAX_MAPS];
    prm_pkg::entry_t                rd_entry;
    prm_pkg::entry_t                new_entry;
    logic                           is_move, is_bottom, full, wrap, add_ok;

    assign rsp_data  = out_reg;
    assign is_bottom = (item_reg.cmd == prm_pkg::CMD_BOTTOM);
    assign is_move   = (item_reg.cmd == prm_pkg::CMD_DELETE) ||
                       (item_reg.cmd == prm_pkg::CMD_TOP) || is_bottom;

    // Per-slot matching against the captured request.
    always_comb
    begin
        used = '0;
        for (int i = 0; i < prm_pkg::MAX_MAPS; i++)
        begin
            live[i]  = (i < int'(cnt_reg));
            pend[i]  = slot_reg[i].delta +
                       ((slot_reg[i].size == 64'd0) ? 64'd0 : slot_reg[i].size - 64'd1);
            vhit[i]  = live[i] && (slot_reg[i].size != 64'd0) &&
                       (slot_reg[i].base <= item_reg.addr) &&
                       ((item_reg.addr - slot_reg[i].base) < slot_reg[i].size);
            phit[i]  = live[i] && (slot_reg[i].delta <= item_reg.phys_addr) &&
                       (item_reg.phys_addr <= pend[i]);
            idhit[i] = live[i] && (32'(slot_reg[i].id) == 32'(item_reg.map_id));
            if (live[i])
            begin
                used[slot_reg[i].id] = 1'b1;
            end
        end
    end

    // Priority encoders: the topmost hit wins for lookups.
    always_comb
    begin
        vidx    = '0;
        pidx    = '0;
        fidx    = '0;
        free_id = '0;
        for (int i = 0; i < prm_pkg::MAX_MAPS; i++)
        begin
            if (vhit[i])
            begin
                vidx = prm_pkg::IDX_W'(i);
            end
            if (phit[i])
            begin
                pidx = prm_pkg::IDX_W'(i);
            end
            if (idhit[i])
            begin
                fidx = prm_pkg::IDX_W'(i);
            end
        end
        for (int j = prm_pkg::MAX_MAPS; j >= 1; j--)
        begin
            if (!used[j])
            begin
                free_id = prm_pkg::ID_W'(j);
            end
        end
    end

    // Single read port shared by evaluation and shifting.
    always_comb
    begin
        if (cmd.eval)
        begin
            case (item_reg.cmd)
                prm_pkg::CMD_VLOOK: rd_addr = vidx;
                prm_pkg::CMD_PLOOK: rd_addr = pidx;
                default:            rd_addr = fidx;
            endcase
        end
        else if (is_bottom)
        begin
            rd_addr = ptr_reg - prm_pkg::IDX_W'(1);
        end
        else
        begin
            rd_addr = ptr_reg + prm_pkg::IDX_W'(1);
        end
    end
    assign rd_entry = slot_reg[rd_addr];

    // Add checks and the new entry.
    assign full    = (cnt_reg == prm_pkg::CNT_W'(prm_pkg::MAX_MAPS));
    assign wrap    = (item_reg.size != 64'd0) && ((64'd0 - item_reg.size) < item_reg.addr);
    assign add_ok  = (item_reg.cmd == prm_pkg::CMD_ADD) && !full && !wrap;
    assign new_entry = '{id: free_id, fd: item_reg.fd, perm: item_reg.perm,
                         base: item_reg.addr, size: item_reg.size, delta: item_reg.delta};

    // Status to the controller.
    assign sts.move_hit   = is_move && (|idhit);
    assign sts.shift_done = is_bottom ? (ptr_reg == '0)
                                      : (32'(ptr_reg) + 32'd1 >= 32'(cnt_reg));

    // Result of the evaluation cycle.
    always_comb
    begin
        res_next        = '0;
        res_next.status = prm_pkg::ST_MISS;
        case (item_reg.cmd)
            prm_pkg::CMD_ADD:
            begin
                if (full)
                begin
                    res_next.status = prm_pkg::ST_FULL;
                end
                else if (wrap)
                begin
                    res_next.status = prm_pkg::ST_WRAP;
                end
                else
                begin
                    res_next = prm_pkg::report(new_entry);
                end
            end
            prm_pkg::CMD_DELETE, prm_pkg::CMD_TOP, prm_pkg::CMD_BOTTOM:
            begin
                if (|idhit)
                begin
                    res_next = prm_pkg::report(rd_entry);
                end
            end
            prm_pkg::CMD_VLOOK:
            begin
                if (|vhit)
                begin
                    res_next = prm_pkg::report(rd_entry);
                end
            end
            prm_pkg::CMD_PLOOK:
            begin
                if (|phit)
                begin
                    res_next = prm_pkg::report(rd_entry);
                end
            end
            default:
            begin
                res_next.status = prm_pkg::ST_MISS;
            end
        endcase
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.eval && add_ok)
        begin
            cnt_reg <= cnt_reg + prm_pkg::CNT_W'(1);
        end
        else if (cmd.place && (item_reg.cmd == prm_pkg::CMD_DELETE))
        begin
            cnt_reg <= cnt_reg - prm_pkg::CNT_W'(1);
        end
    end

    // Slots, holding entry, pointer and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            item_reg <= req_data;
        end
        if (cmd.eval)
        begin
            hold_reg <= rd_entry;
            ptr_reg  <= fidx;
            res_reg  <= res_next;
            if (add_ok)
            begin
                slot_reg[cnt_reg[prm_pkg::IDX_W-1:0]] <= new_entry;
            end
        end
        if (cmd.step)
        begin
            slot_reg[ptr_reg] <= rd_entry;
            ptr_reg <= is_bottom ? ptr_reg - prm_pkg::IDX_W'(1)
                                 : ptr_reg + prm_pkg::IDX_W'(1);
        end
        if (cmd.place && (item_reg.cmd != prm_pkg::CMD_DELETE))
        begin
            slot_reg[ptr_reg] <= hold_reg;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

`ifndef SYNTHESIS
    // The table never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= prm_pkg::CNT_W'(prm_pkg::MAX_MAPS))
        else $error("entry count above table depth");

    // A shift step always works on a live slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (32'(ptr_reg) < 32'(cnt_reg)))
        else $error("shift pointer outside live slots");

    // An add that succeeds grows the table by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.eval && add_ok) |=> (cnt_reg == $past(cnt_reg) + prm_pkg::CNT_W'(1)))
        else $error("add did not grow the table");
`endif

endmodule
